// ----- hdl/fbpa_pkg.sv -----
// Shared constants, types and codes for the fixed block pool allocator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package fbpa_pkg;

    // Pool geometry. BLOCK_BYTES must be a power of two.
    localparam int NUM_BLOCKS  = 32;
    localparam int BLOCK_BYTES = 128;

    localparam int ADDR_W = 32;
    localparam int FREE_W = 6;
    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam logic [ADDR_W-1:0] SPAN = ADDR_W'(NUM_BLOCKS * BLOCK_BYTES);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [FREE_W-1:0] free_cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_RELEASE = 2'd1,
        STATUS_EMPTY       = 2'd2
    } status_t;

    typedef struct packed {
        kind_t kind;
        addr_t block_addr;
    } in_item_t;

    typedef struct packed {
        status_t   status;
        addr_t     granted_addr;
        free_cnt_t free_count;
    } out_item_t;

    // Control from the sequencer to the free ring
    typedef struct packed {
        logic rd_en;     // read the entry at the head pointer
        logic pop;       // advance the head pointer
        logic push;      // write push_idx at the tail pointer
        idx_t push_idx;
    } ring_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/fbpa_ring.sv -----
// Free ring: block index memory with head/tail pointers.
// Depends on fbpa_pkg. Reset contents come from an overlay, not a sweep.
`default_nettype none

module fbpa_ring (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fbpa_pkg::ring_ctrl_t ctrl,
    output fbpa_pkg::idx_t           rd_idx
);

    localparam fbpa_pkg::idx_t LAST_IDX = fbpa_pkg::idx_t'(fbpa_pkg::NUM_BLOCKS - 1);

    fbpa_pkg::idx_t ring_mem [fbpa_pkg::NUM_BLOCKS];

    fbpa_pkg::idx_t head_reg, head_next;
    fbpa_pkg::idx_t tail_reg, tail_next;
    logic           wrapped_reg, wrapped_next;
    fbpa_pkg::idx_t rd_data_reg;
    fbpa_pkg::idx_t dflt_reg;
    logic           written_reg;

    // Pointer advance with wrap at the pool size
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        wrapped_next = wrapped_reg;
        if (ctrl.pop) begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push) begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            if (tail_reg == LAST_IDX) begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Memory: one write port at the tail, one registered read at the head
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            ring_mem[tail_reg] <= ctrl.push_idx;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= ring_mem[head_reg];
        end
    end

    // Pushes fill entries in order from zero, so an entry has been written
    // once the tail has passed it. Until then it holds its reset index.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            written_reg <= wrapped_reg || (head_reg < tail_reg);
            dflt_reg    <= LAST_IDX - head_reg;
        end
    end

    assign rd_idx = written_reg ? rd_data_reg : dflt_reg;

endmodule

`default_nettype wire

// ----- hdl/fbpa_rel_check.sv -----
// Release address check: null, range, alignment, full-pool and double-release tests.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_rel_check (
    input  wire fbpa_pkg::addr_t              block_addr,
    input  wire fbpa_pkg::addr_t              heap_base,
    input  wire logic [fbpa_pkg::NUM_BLOCKS-1:0] free_map,
    input  wire fbpa_pkg::cnt_t               free_total,
    output logic                              rel_ok,
    output fbpa_pkg::idx_t                    rel_idx
);

    fbpa_pkg::addr_t offset;
    logic            in_range;
    logic            aligned;

    // Offset from the pool base, modulo 2^32
    assign offset   = block_addr - heap_base;
    assign in_range = offset < fbpa_pkg::SPAN;
    assign aligned  = (offset[fbpa_pkg::OFF_W-1:0] == '0);
    assign rel_idx  = offset[fbpa_pkg::OFF_W +: fbpa_pkg::IDX_W];

    always_comb begin
        rel_ok = (block_addr != '0) && in_range && aligned
              && (free_total < fbpa_pkg::cnt_t'(fbpa_pkg::NUM_BLOCKS));
        if (rel_ok && free_map[rel_idx]) begin
            rel_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fixed_block_pool_allocator_unit.sv -----
// Flow: an accepted item is registered along with the free ring read at the head; the sequencer
// then commits the pop or push and registers the result. A new item is taken only in idle,
// after the previous item has committed. Output backpressure holds back the commit.
// Reset (synchronous, aresetn low): ring reads as indices 31 down to 0 through a written
// overlay, no clearing pass; all blocks free; heap_base is 0.
`default_nettype none

module fixed_block_pool_allocator_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire fbpa_pkg::addr_t     cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fbpa_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fbpa_pkg::out_item_t      m_item
);

    fbpa_pkg::state_t    state_reg, state_next;
    fbpa_pkg::in_item_t  item_reg;
    fbpa_pkg::addr_t     heap_base_reg;
    logic [fbpa_pkg::NUM_BLOCKS-1:0] free_map_reg, free_map_next;
    fbpa_pkg::cnt_t      free_total_reg, free_total_next;
    logic                m_valid_reg, m_valid_next;
    fbpa_pkg::out_item_t m_item_reg, m_item_next;

    fbpa_pkg::ring_ctrl_t ring_ctrl;
    fbpa_pkg::idx_t       rd_idx;
    logic                 rel_ok;
    fbpa_pkg::idx_t       rel_idx;
    logic                 fire;
    logic                 is_req;
    logic                 req_ok;
    logic                 push_ok;
    fbpa_pkg::addr_t      grant_addr;

    fbpa_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .rd_idx  (rd_idx)
    );

    fbpa_rel_check u_rel_check (
        .block_addr (item_reg.block_addr),
        .heap_base  (heap_base_reg),
        .free_map   (free_map_reg),
        .free_total (free_total_reg),
        .rel_ok     (rel_ok),
        .rel_idx    (rel_idx)
    );

    assign is_req  = (item_reg.kind == fbpa_pkg::KIND_REQUEST);
    assign req_ok  = is_req && (free_total_reg != '0);
    assign push_ok = !is_req && rel_ok;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fbpa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fbpa_pkg::ST_EXEC;
                end
            end
            fbpa_pkg::ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = fbpa_pkg::ST_IDLE;
                end
            end
            default: state_next = fbpa_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        fire    = 1'b0;
        case (state_reg)
            fbpa_pkg::ST_IDLE: s_ready = 1'b1;
            fbpa_pkg::ST_EXEC: fire    = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
                fire    = 1'b0;
            end
        endcase
        ring_ctrl.rd_en    = s_valid && s_ready;
        ring_ctrl.pop      = fire && req_ok;
        ring_ctrl.push     = fire && push_ok;
        ring_ctrl.push_idx = rel_idx;
    end

    // Granted address: base plus index times block size
    assign grant_addr = heap_base_reg
        + {{(fbpa_pkg::ADDR_W - fbpa_pkg::IDX_W - fbpa_pkg::OFF_W){1'b0}},
           rd_idx, {fbpa_pkg::OFF_W{1'b0}}};

    // Free bitmap, free count and result item
    always_comb begin
        free_map_next   = free_map_reg;
        free_total_next = free_total_reg;
        if (ring_ctrl.pop) begin
            free_map_next[rd_idx] = 1'b0;
            free_total_next       = free_total_reg - 1'b1;
        end
        if (ring_ctrl.push) begin
            free_map_next[rel_idx] = 1'b1;
            free_total_next        = free_total_reg + 1'b1;
        end

        m_item_next.free_count   = fbpa_pkg::free_cnt_t'(free_total_next);
        m_item_next.granted_addr = req_ok ? grant_addr : '0;
        if (is_req) begin
            m_item_next.status = req_ok ? fbpa_pkg::STATUS_OK : fbpa_pkg::STATUS_EMPTY;
        end else begin
            m_item_next.status = rel_ok ? fbpa_pkg::STATUS_OK : fbpa_pkg::STATUS_BAD_RELEASE;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (fire) begin
            m_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fbpa_pkg::ST_IDLE;
            heap_base_reg  <= '0;
            free_map_reg   <= '1;
            free_total_reg <= fbpa_pkg::cnt_t'(fbpa_pkg::NUM_BLOCKS);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_map_reg   <= free_map_next;
            free_total_reg <= free_total_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                heap_base_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        if (fire) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The ring is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ring_ctrl.rd_en && (ring_ctrl.push || ring_ctrl.pop)))
        else $error("ring read overlaps a pop or push");

    // Free count tracks the bitmap
    a_count_matches_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(free_map_reg) == int'(free_total_reg))
        else $error("free count disagrees with free bitmap");

    // A popped block must have been free
    a_pop_was_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ctrl.pop |-> free_map_reg[rd_idx])
        else $error("granted a block that was not free");

    // An item accepted while no result is pending yields a result once the sequencer fires
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid_reg) |=> ##1 m_valid_reg)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
